### design/nibble_delta_rle_depth_decoder_macros.svh
// Assertion helpers used by the decoder module.
`ifndef NIBBLE_DELTA_RLE_DEPTH_DECODER_MACROS_SVH
`define NIBBLE_DELTA_RLE_DEPTH_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define NDRD_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`define NDRD_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define NDRD_ASSERT_IMP(label, clk, rstn, ante, cons)

`define NDRD_ASSERT_NXT(label, clk, rstn, ante, cons)

`endif

`endif

### design/ndrd_pkg.sv
package ndrd_pkg;

    localparam int LIMIT_W = 21;
    localparam int CFG_W   = 21;
    localparam int VALUE_W = 16;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MAX_SHIFT  = 2'd0;
    localparam logic [1:0] CFG_NO_DEPTH   = 2'd1;
    localparam logic [1:0] CFG_PIXEL_LIM  = 2'd2;

    localparam logic [VALUE_W-1:0] MAX_SHIFT_RST = 16'd2047;
    localparam logic [VALUE_W-1:0] NO_DEPTH_RST  = 16'd0;
    localparam logic [LIMIT_W-1:0] PIXEL_LIM_RST = 21'd307200;

    // Opcode nibbles.
    localparam logic [3:0] CODE_FILL = 4'hD;
    localparam logic [3:0] CODE_RUN  = 4'hE;
    localparam logic [3:0] CODE_ESC  = 4'hF;

    localparam logic [VALUE_W-1:0] SMALL_BIAS = 16'd6;
    localparam logic [VALUE_W-1:0] LARGE_BIAS = 16'd64;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_frame;
    } ndrd_in_t;

    typedef struct packed {
        logic [VALUE_W-1:0] depth_shift;
        logic               last_of_run;
        logic               overflow;
    } ndrd_out_t;

    typedef enum logic [2:0] {
        PH_OPCODE   = 3'd0,
        PH_COUNT    = 3'd1,
        PH_SELECT   = 3'd2,
        PH_DELTA_LO = 3'd3,
        PH_FULL1    = 3'd4,
        PH_FULL2    = 3'd5,
        PH_FULL3    = 3'd6
    } ndrd_phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_NIB,
        ST_RUN,
        ST_FLUSH
    } ndrd_state_t;

    typedef struct packed {
        logic push;
        logic flush;
    } ndrd_ost_ctrl_t;

    typedef struct packed {
        logic ready;
        logic pend_valid;
    } ndrd_ost_stat_t;

endpackage

### design/nibble_delta_rle_depth_decoder.sv
// A byte is decoded one nibble per cycle after the accept cycle while the output stage is
// ready and no repeat code is being expanded; its last result waits in the pending register
// and moves to the m_ output register in the flush state. A repeat code emits count+1 copies;
// a new byte waits until the decoder is idle again. At most one result is emitted per cycle.
// Reset: aresetn is synchronous and active low; it restores the register defaults and clears
// the decoder state, pixel counter and output valid flags. No clearing pass is needed.
`include "nibble_delta_rle_depth_decoder_macros.svh"

module nibble_delta_rle_depth_decoder #(
    parameter int COUNT_BITS = 21
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [1:0]                      cfg_addr,
    input  logic [ndrd_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  ndrd_pkg::ndrd_in_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output ndrd_pkg::ndrd_out_t             m_data
);

    localparam int CMP_W = (COUNT_BITS > ndrd_pkg::LIMIT_W) ? COUNT_BITS : ndrd_pkg::LIMIT_W;

    logic [ndrd_pkg::VALUE_W-1:0] max_shift_reg;
    logic [ndrd_pkg::VALUE_W-1:0] no_depth_reg;
    logic [ndrd_pkg::LIMIT_W-1:0] pixel_limit_reg;

    ndrd_pkg::ndrd_state_t        state_reg;
    ndrd_pkg::ndrd_state_t        state_next;
    ndrd_pkg::ndrd_phase_t        phase_reg;
    ndrd_pkg::ndrd_phase_t        phase_next;
    logic [10:0]                  partial_reg;
    logic [10:0]                  partial_next;
    logic [ndrd_pkg::VALUE_W-1:0] running_reg;
    logic [ndrd_pkg::VALUE_W-1:0] running_next;
    logic [COUNT_BITS-1:0]        count_reg;
    logic [COUNT_BITS-1:0]        count_next;
    logic                         ovf_seen_reg;
    logic                         ovf_seen_next;
    logic [7:0]                   byte_reg;
    logic [7:0]                   byte_next;
    logic                         nib_sel_reg;
    logic                         nib_sel_next;
    logic [3:0]                   run_cnt_reg;
    logic [3:0]                   run_cnt_next;

    logic [3:0]                   nib;
    logic                         emit_req;
    logic [ndrd_pkg::VALUE_W-1:0] emit_val;
    logic [ndrd_pkg::VALUE_W-1:0] clamp_val;
    logic                         limit_hit;
    logic                         advance;

    ndrd_pkg::ndrd_ost_ctrl_t     ost_ctrl;
    ndrd_pkg::ndrd_ost_stat_t     ost_stat;
    ndrd_pkg::ndrd_out_t          push_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_shift_reg   <= ndrd_pkg::MAX_SHIFT_RST;
            no_depth_reg    <= ndrd_pkg::NO_DEPTH_RST;
            pixel_limit_reg <= ndrd_pkg::PIXEL_LIM_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                ndrd_pkg::CFG_MAX_SHIFT: max_shift_reg   <= cfg_wdata[ndrd_pkg::VALUE_W-1:0];
                ndrd_pkg::CFG_NO_DEPTH:  no_depth_reg    <= cfg_wdata[ndrd_pkg::VALUE_W-1:0];
                ndrd_pkg::CFG_PIXEL_LIM: pixel_limit_reg <= cfg_wdata[ndrd_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // The byte shifts left one nibble per step, so the current nibble is always on top.
    assign nib       = byte_reg[7:4];
    assign limit_hit = CMP_W'(count_reg) >= CMP_W'(pixel_limit_reg);
    assign clamp_val = (emit_val >= max_shift_reg) ? no_depth_reg : emit_val;
    assign s_ready   = (state_reg == ndrd_pkg::ST_IDLE);

    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        partial_next   = partial_reg;
        running_next   = running_reg;
        count_next     = count_reg;
        ovf_seen_next  = ovf_seen_reg;
        byte_next      = byte_reg;
        nib_sel_next   = nib_sel_reg;
        run_cnt_next   = run_cnt_reg;
        emit_req       = 1'b0;
        emit_val       = running_reg;
        advance        = 1'b0;
        ost_ctrl.flush = 1'b0;

        case (state_reg)
            ndrd_pkg::ST_IDLE: begin
                if (s_valid) begin
                    byte_next    = s_data.data_byte;
                    nib_sel_next = 1'b0;
                    state_next   = ndrd_pkg::ST_NIB;
                    if (s_data.start_frame) begin
                        phase_next    = ndrd_pkg::PH_OPCODE;
                        running_next  = '0;
                        count_next    = '0;
                        ovf_seen_next = 1'b0;
                    end
                end
            end
            ndrd_pkg::ST_NIB: begin
                if (ovf_seen_reg) begin
                    advance = 1'b1;
                end else begin
                    case (phase_reg)
                        ndrd_pkg::PH_COUNT: begin
                            run_cnt_next = nib;
                            phase_next   = ndrd_pkg::PH_OPCODE;
                            state_next   = ndrd_pkg::ST_RUN;
                        end
                        ndrd_pkg::PH_SELECT: begin
                            // The top bit picks the large delta or the full value form.
                            partial_next = {8'd0, nib[2:0]};
                            phase_next   = nib[3] ? ndrd_pkg::PH_DELTA_LO : ndrd_pkg::PH_FULL1;
                            advance      = 1'b1;
                        end
                        ndrd_pkg::PH_DELTA_LO: begin
                            emit_req = 1'b1;
                            emit_val = running_reg + ndrd_pkg::VALUE_W'({partial_reg[2:0], nib})
                                       - ndrd_pkg::LARGE_BIAS;
                            if (ost_stat.ready) begin
                                phase_next = ndrd_pkg::PH_OPCODE;
                                advance    = 1'b1;
                            end
                        end
                        ndrd_pkg::PH_FULL1: begin
                            partial_next = {partial_reg[6:0], nib};
                            phase_next   = ndrd_pkg::PH_FULL2;
                            advance      = 1'b1;
                        end
                        ndrd_pkg::PH_FULL2: begin
                            partial_next = {partial_reg[6:0], nib};
                            phase_next   = ndrd_pkg::PH_FULL3;
                            advance      = 1'b1;
                        end
                        ndrd_pkg::PH_FULL3: begin
                            emit_req = 1'b1;
                            emit_val = {1'b0, partial_reg, nib};
                            if (ost_stat.ready) begin
                                phase_next = ndrd_pkg::PH_OPCODE;
                                advance    = 1'b1;
                            end
                        end
                        default: begin
                            case (nib)
                                ndrd_pkg::CODE_FILL: begin
                                    phase_next = ndrd_pkg::PH_OPCODE;
                                    advance    = 1'b1;
                                end
                                ndrd_pkg::CODE_RUN: begin
                                    phase_next = ndrd_pkg::PH_COUNT;
                                    advance    = 1'b1;
                                end
                                ndrd_pkg::CODE_ESC: begin
                                    phase_next = ndrd_pkg::PH_SELECT;
                                    advance    = 1'b1;
                                end
                                default: begin
                                    emit_req = 1'b1;
                                    emit_val = running_reg + ndrd_pkg::VALUE_W'(nib)
                                               - ndrd_pkg::SMALL_BIAS;
                                    if (ost_stat.ready) begin
                                        phase_next = ndrd_pkg::PH_OPCODE;
                                        advance    = 1'b1;
                                    end
                                end
                            endcase
                        end
                    endcase
                end
            end
            ndrd_pkg::ST_RUN: begin
                if (ovf_seen_reg) begin
                    advance = 1'b1;
                end else begin
                    emit_req = 1'b1;
                    if (ost_stat.ready) begin
                        if (run_cnt_reg == 4'd0) begin
                            advance = 1'b1;
                        end else begin
                            run_cnt_next = run_cnt_reg - 4'd1;
                        end
                    end
                end
            end
            ndrd_pkg::ST_FLUSH: begin
                ost_ctrl.flush = 1'b1;
                if (ost_stat.ready) begin
                    state_next = ndrd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ndrd_pkg::ST_IDLE;
            end
        endcase

        // Once the pixel limit is reached, the one result left is the overflow marker.
        push_data.depth_shift = limit_hit ? '0 : clamp_val;
        push_data.last_of_run = 1'b0;
        push_data.overflow    = limit_hit;
        ost_ctrl.push = emit_req && ost_stat.ready;
        if (ost_ctrl.push) begin
            if (limit_hit) begin
                ovf_seen_next = 1'b1;
                running_next  = emit_val;
            end else begin
                running_next = clamp_val;
                if (count_reg != {COUNT_BITS{1'b1}}) begin
                    count_next = count_reg + COUNT_BITS'(1);
                end
            end
        end

        if (advance) begin
            if (nib_sel_reg) begin
                state_next = ndrd_pkg::ST_FLUSH;
            end else begin
                nib_sel_next = 1'b1;
                byte_next    = {byte_reg[3:0], 4'd0};
                state_next   = ndrd_pkg::ST_NIB;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ndrd_pkg::ST_IDLE;
            phase_reg    <= ndrd_pkg::PH_OPCODE;
            running_reg  <= '0;
            count_reg    <= '0;
            ovf_seen_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            running_reg  <= running_next;
            count_reg    <= count_next;
            ovf_seen_reg <= ovf_seen_next;
        end
        partial_reg <= partial_next;
        byte_reg    <= byte_next;
        nib_sel_reg <= nib_sel_next;
        run_cnt_reg <= run_cnt_next;
    end

    ndrd_out_stage u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ost_ctrl),
        .push_data (push_data),
        .stat      (ost_stat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    `NDRD_ASSERT_NXT(a_start_clears, aclk, aresetn, s_valid && s_ready && s_data.start_frame, count_reg == '0 && !ovf_seen_reg)
    `NDRD_ASSERT_IMP(a_idle_no_pending, aclk, aresetn, state_reg == ndrd_pkg::ST_IDLE, !ost_stat.pend_valid)
    `NDRD_ASSERT_IMP(a_overflow_zero, aclk, aresetn, m_valid && m_data.overflow, m_data.depth_shift == '0)
    `NDRD_ASSERT_NXT(a_dropped_count_holds, aclk, aresetn, ovf_seen_reg && !(s_valid && s_ready), $stable(count_reg))

endmodule

### design/ndrd_out_stage.sv
module ndrd_out_stage (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ndrd_pkg::ndrd_ost_ctrl_t ctrl,
    input  ndrd_pkg::ndrd_out_t    push_data,
    output ndrd_pkg::ndrd_ost_stat_t stat,
    output logic                   m_valid,
    input  logic                   m_ready,
    output ndrd_pkg::ndrd_out_t    m_data
);

    // One result is held back until it is known whether it ends its byte.
    logic                pend_valid_reg;
    logic                pend_valid_next;
    ndrd_pkg::ndrd_out_t pend_data_reg;
    ndrd_pkg::ndrd_out_t pend_data_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    ndrd_pkg::ndrd_out_t out_data_reg;
    ndrd_pkg::ndrd_out_t out_data_next;
    logic                out_free;
    logic                stage_ready;

    assign out_free    = !out_valid_reg || m_ready;
    assign stage_ready = !pend_valid_reg || out_free;

    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_data_next  = pend_data_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (ctrl.push && stage_ready) begin
            if (pend_valid_reg) begin
                out_valid_next            = 1'b1;
                out_data_next             = pend_data_reg;
                out_data_next.last_of_run = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_data_next  = push_data;
        end else if (ctrl.flush && stage_ready && pend_valid_reg) begin
            out_valid_next            = 1'b1;
            out_data_next             = pend_data_reg;
            out_data_next.last_of_run = 1'b1;
            pend_valid_next           = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
        pend_data_reg <= pend_data_next;
        out_data_reg  <= out_data_next;
    end

    assign stat.ready      = stage_ready;
    assign stat.pend_valid = pend_valid_reg;
    assign m_valid         = out_valid_reg;
    assign m_data          = out_data_reg;

endmodule
